@@ hw/rtl/polyline_closest_arc_position_core_macros.svh @@
// Assertion macros for the closest-arc-position core checker.
// Depends on nothing; the including module supplies clk and rst.
`ifndef POLYLINE_CLOSEST_ARC_POSITION_CORE_MACROS_SVH
`define POLYLINE_CLOSEST_ARC_POSITION_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PCAP_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcap check failed");

// next-cycle implication, checked outside reset
`define PCAP_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcap check failed");

`endif

@@ hw/rtl/pcap_pkg.sv @@
// Shared widths and sequencer state type for the closest-arc-position core.
// Used by the bit-serial units and the top level; depends on nothing.
package pcap_pkg;

  localparam int MW = 68;   // dot products, squared lengths, divisor
  localparam int RW = 34;   // multiplier digit operand, square root
  localparam int PW = 102;  // full product width
  localparam int QW = 35;   // quotient bits
  localparam int CW = 6;    // iteration counter

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PA,
    ST_PB,
    ST_C2X,
    ST_C2Y,
    ST_CLASS,
    ST_SQRT,
    ST_OFFMUL,
    ST_OFFDIV,
    ST_MXMUL,
    ST_MXDIV,
    ST_MYMUL,
    ST_MYDIV,
    ST_FOOT,
    ST_DX,
    ST_DY,
    ST_UPDATE,
    ST_OUT
  } state_t;

  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? (33'd0 - v) : v;
  endfunction

endpackage

@@ hw/rtl/polyline_closest_arc_position_core.sv @@
// Closest point on a 2D polyline, reported as an arc position (Q16.16).
// First vertex of a polyline is only stored, next vertex taken the next cycle;
// a segment with its foot at the start or end vertex needs the dot product, squared
// length and distance; an interior foot point also a root and three multiply-divides.
// No new vertex is taken until the segment is done; a final result waits until taken.
// Reset (rst, synchronous): config registers to defaults, search cleared, sequencer idle.
module polyline_closest_arc_position_core import pcap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] vertex_x,
  input  logic [31:0] vertex_y,
  input  logic [31:0] vertex_arc,
  input  logic        final_vertex,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] arc_position
);

  localparam logic [1:0] REG_QUERY_X     = 2'd0;
  localparam logic [1:0] REG_QUERY_Y     = 2'd1;
  localparam logic [1:0] REG_WINDOW_LOW  = 2'd2;
  localparam logic [1:0] REG_WINDOW_HIGH = 2'd3;

  logic [31:0] query_x, query_y, window_low, window_high;

  state_t state, state_next;
  logic   issued;

  logic [31:0] prev_x, prev_y, prev_arc;
  logic        have_prev;
  logic [63:0] best_dist_sq;
  logic [31:0] best_arc;
  logic        any_found;

  logic [32:0]   vx, vy, wx, wy, ex, ey;
  logic [31:0]   a0, a1;
  logic          fin;
  logic [MW-1:0] pa, c2x, c1, c2, sqx;
  logic [PW-1:0] numr;
  logic [RW-1:0] len, dxm, dym;
  logic [QW-1:0] mx;
  logic [31:0]   cand_arc;

  logic          mul_start, div_start, sqrt_start;
  logic          mul_done, div_done, sqrt_done;
  logic [MW-1:0] mul_a;
  logic [RW-1:0] mul_b;
  logic [PW-1:0] mul_prod;
  logic [QW-1:0] div_quo;
  logic [RW-1:0] sqrt_root;

  logic          in_take, cfg_write;
  logic [MW-1:0] pb_s, pa_s;
  logic          c1_le0, c2_le_c1;
  logic [35:0]   arc_sum;
  logic [36:0]   wx_e, wy_e, mx_e, my_e, dxs, dys;
  logic [MW:0]   dsum;
  logic [63:0]   dcand;
  logic          in_window, better;

  assign in_take   = in_valid && (state == ST_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x     <= '0;
      query_y     <= '0;
      window_low  <= '0;
      window_high <= '1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_QUERY_X:     query_x     <= pwdata;
        REG_QUERY_Y:     query_y     <= pwdata;
        REG_WINDOW_LOW:  window_low  <= pwdata;
        REG_WINDOW_HIGH: window_high <= pwdata;
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_QUERY_X:     prdata = query_x;
      REG_QUERY_Y:     prdata = query_y;
      REG_WINDOW_LOW:  prdata = window_low;
      REG_WINDOW_HIGH: prdata = window_high;
      default:         prdata = '0;
    endcase
  end

  // combinational helpers
  assign pa_s     = (wx[32] ^ vx[32]) ? (MW'(0) - pa) : pa;
  assign pb_s     = (wy[32] ^ vy[32]) ? (MW'(0) - mul_prod[MW-1:0]) : mul_prod[MW-1:0];
  assign c1_le0   = c1[MW-1] || (c1 == '0);
  assign c2_le_c1 = c2 <= c1;
  assign arc_sum  = 36'(a0) + 36'(div_quo);
  assign wx_e     = {{4{wx[32]}}, wx};
  assign wy_e     = {{4{wy[32]}}, wy};
  assign mx_e     = 37'(mx);
  assign my_e     = 37'(div_quo);
  assign dxs      = vx[32] ? (wx_e + mx_e) : (wx_e - mx_e);
  assign dys      = vy[32] ? (wy_e + my_e) : (wy_e - my_e);
  assign dsum     = {1'b0, sqx} + {1'b0, mul_prod[MW-1:0]};
  assign dcand    = (dsum[MW:64] != '0) ? '1 : dsum[63:0];
  assign in_window = (cand_arc >= window_low) && (cand_arc <= window_high);
  assign better    = !any_found || (dcand < best_dist_sq);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (have_prev)         state_next = ST_PA;
          else if (final_vertex) state_next = ST_OUT;
        end
      end
      ST_PA:     if (mul_done) state_next = ST_PB;
      ST_PB:     if (mul_done) state_next = ST_C2X;
      ST_C2X:    if (mul_done) state_next = ST_C2Y;
      ST_C2Y:    if (mul_done) state_next = ST_CLASS;
      ST_CLASS:  state_next = (c1_le0 || c2_le_c1) ? ST_DX : ST_SQRT;
      ST_SQRT:   if (sqrt_done) state_next = ST_OFFMUL;
      ST_OFFMUL: if (mul_done) state_next = ST_OFFDIV;
      ST_OFFDIV: if (div_done) state_next = ST_MXMUL;
      ST_MXMUL:  if (mul_done) state_next = ST_MXDIV;
      ST_MXDIV:  if (div_done) state_next = ST_MYMUL;
      ST_MYMUL:  if (mul_done) state_next = ST_MYDIV;
      ST_MYDIV:  if (div_done) state_next = ST_DX;
      ST_DX:     if (mul_done) state_next = ST_DY;
      ST_DY:     if (mul_done) state_next = ST_UPDATE;
      ST_UPDATE: state_next = fin ? ST_OUT : ST_IDLE;
      ST_OUT:    if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // unit launch and operand select
  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_PA: begin
        mul_start = !issued;
        mul_a     = MW'(mag33(wx));
        mul_b     = RW'(mag33(vx));
      end
      ST_PB: begin
        mul_start = !issued;
        mul_a     = MW'(mag33(wy));
        mul_b     = RW'(mag33(vy));
      end
      ST_C2X: begin
        mul_start = !issued;
        mul_a     = MW'(mag33(vx));
        mul_b     = RW'(mag33(vx));
      end
      ST_C2Y: begin
        mul_start = !issued;
        mul_a     = MW'(mag33(vy));
        mul_b     = RW'(mag33(vy));
      end
      ST_SQRT:   sqrt_start = !issued;
      ST_OFFMUL: begin
        mul_start = !issued;
        mul_a     = c1;
        mul_b     = len;
      end
      ST_MXMUL: begin
        mul_start = !issued;
        mul_a     = c1;
        mul_b     = RW'(mag33(vx));
      end
      ST_MYMUL: begin
        mul_start = !issued;
        mul_a     = c1;
        mul_b     = RW'(mag33(vy));
      end
      ST_OFFDIV, ST_MXDIV, ST_MYDIV: div_start = !issued;
      ST_DX: begin
        mul_start = !issued;
        mul_a     = MW'(dxm);
        mul_b     = dxm;
      end
      ST_DY: begin
        mul_start = !issued;
        mul_a     = MW'(dym);
        mul_b     = dym;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      issued       <= 1'b0;
      have_prev    <= 1'b0;
      best_dist_sq <= '1;
      best_arc     <= '0;
      any_found    <= 1'b0;
      prev_x       <= '0;
      prev_y       <= '0;
      prev_arc     <= '0;
    end else begin
      state <= state_next;
      if (mul_start || div_start || sqrt_start) begin
        issued <= 1'b1;
      end else if (mul_done || div_done || sqrt_done) begin
        issued <= 1'b0;
      end
      if (in_take) begin
        prev_x    <= vertex_x;
        prev_y    <= vertex_y;
        prev_arc  <= vertex_arc;
        have_prev <= 1'b1;
      end
      if (state == ST_UPDATE && in_window && better) begin
        any_found    <= 1'b1;
        best_dist_sq <= dcand;
        best_arc     <= cand_arc;
      end
      // drop the search once the result transfer completes
      if (state == ST_OUT && !out_stall) begin
        have_prev    <= 1'b0;
        best_dist_sq <= '1;
        best_arc     <= '0;
        any_found    <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      vx  <= {vertex_x[31], vertex_x} - {prev_x[31], prev_x};
      vy  <= {vertex_y[31], vertex_y} - {prev_y[31], prev_y};
      wx  <= {query_x[31], query_x} - {prev_x[31], prev_x};
      wy  <= {query_y[31], query_y} - {prev_y[31], prev_y};
      ex  <= {query_x[31], query_x} - {vertex_x[31], vertex_x};
      ey  <= {query_y[31], query_y} - {vertex_y[31], vertex_y};
      a0  <= prev_arc;
      a1  <= vertex_arc;
      fin <= final_vertex;
    end
    case (state)
      ST_PA:  if (mul_done) pa  <= mul_prod[MW-1:0];
      ST_PB:  if (mul_done) c1  <= pa_s + pb_s;
      ST_C2X: if (mul_done) c2x <= mul_prod[MW-1:0];
      ST_C2Y: if (mul_done) c2  <= c2x + mul_prod[MW-1:0];
      ST_CLASS: begin
        if (c1_le0) begin
          dxm      <= RW'(mag33(wx));
          dym      <= RW'(mag33(wy));
          cand_arc <= a0;
        end else if (c2_le_c1) begin
          dxm      <= RW'(mag33(ex));
          dym      <= RW'(mag33(ey));
          cand_arc <= a1;
        end
      end
      ST_SQRT:   if (sqrt_done) len <= sqrt_root;
      ST_OFFMUL, ST_MXMUL, ST_MYMUL: if (mul_done) numr <= mul_prod;
      ST_OFFDIV: begin
        if (div_done) begin
          cand_arc <= (arc_sum[35:32] != '0) ? '1 : arc_sum[31:0];
        end
      end
      ST_MXDIV: if (div_done) mx <= div_quo;
      ST_MYDIV: begin
        if (div_done) begin
          dxm <= RW'(dxs[36] ? (37'd0 - dxs) : dxs);
          dym <= RW'(dys[36] ? (37'd0 - dys) : dys);
        end
      end
      ST_DX: if (mul_done) sqx <= mul_prod[MW-1:0];
      default: ;
    endcase
  end

  pcap_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pcap_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (numr),
    .den   (c2),
    .done  (div_done),
    .quo   (div_quo)
  );

  pcap_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (c2),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign in_stall     = (state != ST_IDLE);
  assign out_valid    = (state == ST_OUT);
  assign found        = any_found;
  assign arc_position = best_arc;

endmodule

@@ hw/rtl/pcap_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on pcap_pkg for operand and product widths.
module pcap_mul import pcap_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MW-1:0] a,
  input  logic [RW-1:0] b,
  output logic          done,
  output logic [PW-1:0] prod
);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [PW-1:0] mcand;
  logic [RW-1:0] mplier;
  logic [PW-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= PW'(a);
      mplier <= b;
      acc    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[PW-2:0], 1'b0};
      mplier <= {1'b0, mplier[RW-1:1]};
    end
  end

  assign prod = acc;

endmodule

@@ hw/rtl/pcap_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on pcap_pkg; needs num < den * 2**QW.
module pcap_div import pcap_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] num,
  input  logic [MW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [MW-1:0] rem;
  logic [QW-1:0] nsh;
  logic [MW:0]   trial;
  logic [MW:0]   diff;
  logic          ge;

  assign trial = {rem, nsh[QW-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= MW'(num[PW-1:QW]);
      nsh <= num[QW-1:0];
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? diff[MW-1:0] : trial[MW-1:0];
      nsh <= {nsh[QW-2:0], 1'b0};
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/pcap_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on pcap_pkg; radicand is MW bits, root is RW bits.
module pcap_sqrt import pcap_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [MW-1:0] rad,
  output logic          done,
  output logic [RW-1:0] root
);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [MW-1:0] xs;
  logic [RW+1:0] rem;
  logic [RW+3:0] shifted;
  logic [RW+3:0] trial;
  logic          ge;

  assign shifted = {rem, xs[MW-1:MW-2]};
  assign trial   = (RW + 4)'({root, 2'b01});
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xs   <= {xs[MW-3:0], 2'b00};
      rem  <= ge ? (RW + 2)'(shifted - trial) : (RW + 2)'(shifted);
      root <= {root[RW-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/pcap_checker.sv @@
// Port-level checks for the closest-arc-position core, bound to the top level.
// Depends on polyline_closest_arc_position_core_macros.svh.
`include "polyline_closest_arc_position_core_macros.svh"

module pcap_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        found,
  input logic [31:0] arc_position
);

  `PCAP_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({found, arc_position}))
  `PCAP_HOLDS(a_busy_on_result, out_valid, in_stall)
  `PCAP_HOLDS(a_empty_is_zero, out_valid && !found, arc_position == 32'd0)
  `PCAP_HOLDS(a_idle_no_result, !in_stall, !out_valid)

endmodule

bind polyline_closest_arc_position_core pcap_checker u_pcap_checker (.*);
